>>> design/acrms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acrms_pkg
// Shared widths, register codes and state types of the AC RMS window core.
// ----------------------------------------------------------------------------
package acrms_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int COUNT_W    = 9;
  localparam int FACTOR_W   = 24;
  localparam int RMS_W      = 19;
  localparam int VRMS_W     = 27;
  localparam int FRAC_SHIFT = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [COUNT_W-1:0]  COUNT_MIN    = 9'd10;
  localparam logic [COUNT_W-1:0]  COUNT_RESET  = 9'd200;
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 24'd65536;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_COUNT = 2'd0,
    REG_VOLT_GAIN    = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PROD,
    BK_DIFF,
    BK_ROOT,
    BK_DIV,
    BK_SCALE
  } back_state_t;

endpackage

>>> design/acrms_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acrms_if
// Valid/ready channels of the AC RMS window core: samples, results, config.
// ----------------------------------------------------------------------------
interface acrms_sample_if import acrms_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface acrms_result_if import acrms_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RMS_W-1:0]  rms_count_q8;
  logic [VRMS_W-1:0] vrms_q8;

  modport source (output valid, output rms_count_q8, output vrms_q8, input ready);
  modport sink   (input valid, input rms_count_q8, input vrms_q8, output ready);
endinterface

interface acrms_cfg_if import acrms_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [FACTOR_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/ac_rms_dc_removed_window_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ac_rms_dc_removed_window_core
// Throughput: one sample per cycle while the two-entry window queue has room.
// A result is registered after its window passes the queue and the product,
// difference, bit-serial root (RW = root width, 29 at default parameters),
// bit-serial divide and scale states, root and divide each one bit per cycle.
// Reset: clears window position, sums, queue and result valid; sample_count returns
// to 200 and the voltage gain to 65536.
// ----------------------------------------------------------------------------
module ac_rms_dc_removed_window_core import acrms_pkg::*; #(
  parameter int SAMPLE_BITS = 12,
  parameter int MAX_WINDOW  = 500
) (
  input  logic           clk,
  input  logic           rst,
  acrms_cfg_if.sink      cfg,
  acrms_sample_if.sink   sample,
  acrms_result_if.source result
);

  localparam int SB    = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int CLIM  = (2 ** COUNT_W) - 1;
  localparam int WMAX  = (MAX_WINDOW < CLIM) ? MAX_WINDOW : CLIM;
  localparam int PW    = $clog2(WMAX + 1);
  localparam int S1W   = SB + PW;
  localparam int S2W   = 2 * SB + PW;
  localparam int VW    = 2 * SB + 2 * PW;
  localparam int RW    = (VW + FRAC_SHIFT + 1) / 2;
  localparam int QW    = PW + S1W + S2W;

  logic [COUNT_W-1:0]  sample_count;
  logic [FACTOR_W-1:0] volt_gain;

  logic                push_valid;
  logic                push_ready;
  logic [PW-1:0]       push_n;
  logic [S1W-1:0]      push_s1;
  logic [S2W-1:0]      push_s2;
  logic                win_valid;
  logic                win_ready;
  logic [QW-1:0]       win_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= COUNT_RESET;
      volt_gain    <= FACTOR_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_SAMPLE_COUNT: sample_count <= cfg.data[COUNT_W-1:0];
        REG_VOLT_GAIN:    volt_gain    <= cfg.data;
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  acrms_front #(
    .SB   (SB),
    .WMAX (WMAX),
    .PW   (PW),
    .S1W  (S1W),
    .S2W  (S2W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .sample_count (sample_count),
    .win_valid    (push_valid),
    .win_ready    (push_ready),
    .win_n        (push_n),
    .win_s1       (push_s1),
    .win_s2       (push_s2)
  );

  acrms_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_data   ({push_n, push_s1, push_s2}),
    .out_valid (win_valid),
    .out_ready (win_ready),
    .out_data  (win_data)
  );

  acrms_back #(
    .PW  (PW),
    .S1W (S1W),
    .S2W (S2W),
    .VW  (VW),
    .RW  (RW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .win_valid (win_valid),
    .win_ready (win_ready),
    .win_n     (win_data[QW-1 -: PW]),
    .win_s1    (win_data[S2W +: S1W]),
    .win_s2    (win_data[S2W-1:0]),
    .volt_gain (volt_gain),
    .result    (result)
  );

  a_no_lost_window: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> push_ready)
    else $error("finished window offered to a full queue");

  a_window_len: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> (push_n >= PW'(COUNT_MIN)) && (push_n <= PW'(WMAX)))
    else $error("window closed with a sample count outside the clamp range");

  a_reset_result: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid right after reset");

endmodule

>>> design/acrms_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acrms_front
// Accumulates samples into sum and sum of squares and hands off full windows.
// ----------------------------------------------------------------------------
module acrms_front import acrms_pkg::*; #(
  parameter int SB   = 12,
  parameter int WMAX = 500,
  parameter int PW   = 9,
  parameter int S1W  = 21,
  parameter int S2W  = 33
) (
  input  logic               clk,
  input  logic               rst,
  acrms_sample_if.sink       sample,
  input  logic [COUNT_W-1:0] sample_count,
  output logic               win_valid,
  input  logic               win_ready,
  output logic [PW-1:0]      win_n,
  output logic [S1W-1:0]     win_s1,
  output logic [S2W-1:0]     win_s2
);

  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(WMAX);

  logic [PW-1:0]      position;
  logic [S1W-1:0]     sample_sum;
  logic [S2W-1:0]     square_sum;
  logic [SB-1:0]      x;
  logic [2*SB-1:0]    x_sq;
  logic [COUNT_W-1:0] count_clamped;
  logic [PW-1:0]      window_len;
  logic [PW-1:0]      position_next;
  logic [S1W-1:0]     sample_sum_next;
  logic [S2W-1:0]     square_sum_next;
  logic               accept;
  logic               closing;

  assign x    = sample.adc_sample[SB-1:0];
  assign x_sq = x * x;

  always_comb begin
    if (sample_count < COUNT_MIN) begin
      count_clamped = COUNT_MIN;
    end else if (sample_count > COUNT_MAX) begin
      count_clamped = COUNT_MAX;
    end else begin
      count_clamped = sample_count;
    end
  end

  assign window_len      = count_clamped[PW-1:0];
  assign position_next   = position + 1'b1;
  assign sample_sum_next = sample_sum + S1W'(x);
  assign square_sum_next = square_sum + S2W'(x_sq);
  // a lowered count closes the window on the next sample
  assign closing         = position_next >= window_len;

  // hold off samples while the window queue is full
  assign sample.ready = win_ready;
  assign accept       = sample.valid && sample.ready;

  assign win_valid = accept && closing;
  assign win_n     = position_next;
  assign win_s1    = sample_sum_next;
  assign win_s2    = square_sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= '0;
      sample_sum <= '0;
      square_sum <= '0;
    end else if (accept) begin
      if (closing) begin
        position   <= '0;
        sample_sum <= '0;
        square_sum <= '0;
      end else begin
        position   <= position_next;
        sample_sum <= sample_sum_next;
        square_sum <= square_sum_next;
      end
    end
  end

endmodule

>>> design/acrms_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acrms_queue
// Two-entry queue of finished windows between accumulator and arithmetic.
// ----------------------------------------------------------------------------
module acrms_queue import acrms_pkg::*; #(
  parameter int W = 63
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic [W-1:0]      entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              push;
  logic              pop;

  assign in_ready  = fill != (QPTR_W+1)'(QUEUE_DEPTH);
  assign out_valid = fill != '0;
  assign out_data  = entry[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= in_data;
    end
  end

endmodule

>>> design/acrms_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acrms_isqrt
// Bit-pair integer square root of operand * 2^16, one root bit per cycle.
// ----------------------------------------------------------------------------
module acrms_isqrt import acrms_pkg::*; #(
  parameter int VW = 42,
  parameter int RW = 29
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [VW-1:0] operand,
  output logic          busy,
  output logic [RW-1:0] root
);

  localparam int RADW  = 2 * RW;
  localparam int CNT_W = $clog2(RW + 1);

  logic [RADW-1:0]  rad;
  logic [RW+1:0]    rem;
  logic [RW+1:0]    rem_sh;
  logic [RW+1:0]    trial;
  logic [CNT_W-1:0] steps;
  logic             fits;

  assign rem_sh = {rem[RW-1:0], rad[RADW-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= '0;
    end else if (busy) begin
      steps <= steps + 1'b1;
      if (steps == CNT_W'(RW - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= RADW'(operand) << FRAC_SHIFT;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= rad << 2;
      rem  <= fits ? rem_sh - trial : rem_sh;
      root <= {root[RW-2:0], fits};
    end
  end

endmodule

>>> design/acrms_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acrms_back
// Turns one window into variance, root, mean root and scaled voltage.
// ----------------------------------------------------------------------------
module acrms_back import acrms_pkg::*; #(
  parameter int PW  = 9,
  parameter int S1W = 21,
  parameter int S2W = 33,
  parameter int VW  = 42,
  parameter int RW  = 29
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                win_valid,
  output logic                win_ready,
  input  logic [PW-1:0]       win_n,
  input  logic [S1W-1:0]      win_s1,
  input  logic [S2W-1:0]      win_s2,
  input  logic [FACTOR_W-1:0] volt_gain,
  acrms_result_if.source      result
);

  localparam int CNT_W = $clog2(RW + 1);

  back_state_t                 state;
  back_state_t                 state_next;
  logic [PW-1:0]               n;
  logic [S1W-1:0]              s1;
  logic [S2W-1:0]              s2;
  logic [VW-1:0]               n_s2;
  logic [VW-1:0]               s1_sq;
  logic [VW-1:0]               variance;
  logic                        sq_start;
  logic                        sq_busy;
  logic [RW-1:0]               sq_root;
  logic [RW-1:0]               quot;
  logic [PW-1:0]               rem;
  logic [PW:0]                 rem_sh;
  logic [PW:0]                 rem_diff;
  logic                        fits;
  logic [CNT_W-1:0]            steps;
  logic [RMS_W-1:0]            rms;
  logic [RMS_W+FACTOR_W-1:0]   scaled;
  logic                        out_free;

  assign variance = n_s2 - s1_sq;

  acrms_isqrt #(
    .VW (VW),
    .RW (RW)
  ) u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sq_start),
    .operand (variance),
    .busy    (sq_busy),
    .root    (sq_root)
  );

  // restoring divide: dividend shifts out of quot as quotient bits shift in
  assign rem_sh   = {rem, quot[RW-1]};
  assign rem_diff = rem_sh - {1'b0, n};
  assign fits     = !rem_diff[PW];

  assign rms      = quot[RMS_W-1:0];
  assign scaled   = rms * volt_gain;
  assign out_free = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    win_ready  = 1'b0;
    sq_start   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        win_ready = 1'b1;
        if (win_valid) begin
          state_next = BK_PROD;
        end
      end
      BK_PROD: begin
        state_next = BK_DIFF;
      end
      BK_DIFF: begin
        sq_start   = 1'b1;
        state_next = BK_ROOT;
      end
      BK_ROOT: begin
        if (!sq_busy) begin
          state_next = BK_DIV;
        end
      end
      BK_DIV: begin
        if (steps == CNT_W'(RW - 1)) begin
          state_next = BK_SCALE;
        end
      end
      BK_SCALE: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (win_valid) begin
          n  <= win_n;
          s1 <= win_s1;
          s2 <= win_s2;
        end
      end
      BK_PROD: begin
        n_s2  <= n * s2;
        s1_sq <= s1 * s1;
      end
      BK_ROOT: begin
        if (!sq_busy) begin
          quot  <= sq_root;
          rem   <= '0;
          steps <= '0;
        end
      end
      BK_DIV: begin
        quot  <= {quot[RW-2:0], fits};
        rem   <= fits ? rem_diff[PW-1:0] : rem_sh[PW-1:0];
        steps <= steps + 1'b1;
      end
      BK_SCALE: begin
        if (out_free) begin
          result.rms_count_q8 <= rms;
          result.vrms_q8      <= scaled[FRAC_SHIFT +: VRMS_W];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == BK_SCALE && out_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

endmodule
